// File: rtl/sdf_pkg.sv
// Shared types, codes, defaults and the CRC-16 byte step of the sync-header deframer.
package sdf_pkg;

  // Default sizes, handed down from the top level.
  localparam int MAX_HEADER_DEF = 8;
  localparam int MAX_HELD_DEF   = 32 * 1024;
  localparam int MIN_FRAME_DEF  = 9;

  // Fixed widths of the configuration registers.
  localparam int PATTERN_W = 64;
  localparam int HLEN_W    = 4;

  // Bytes from the header start to the first byte covered by the CRC, plus the
  // two CRC bytes held back in the history.
  localparam int CRC_LAG = 4;

  // Depth of the queue between front and back; a power of two.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic CFG_IDX_PATTERN = 1'b0;
  localparam logic CFG_IDX_LENGTH  = 1'b1;

  typedef enum logic [2:0] {
    ST_GOOD     = 3'd0,
    ST_BAD_CRC  = 3'd1,
    ST_SHORT    = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_RATE     = 3'd4
  } status_t;

  // One classified beat, front to back.
  typedef struct packed {
    logic        tick;      // one-second tick, no byte
    logic        hit;       // header pattern matches ending at this byte
    logic [7:0]  crc_byte;  // byte just before the two tail bytes, for the CRC
    logic [15:0] tail;      // last two bytes before the header window
  } sdf_item_t;

  // CRC-16, polynomial 0x1021, one byte per call.
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = {c[7:0], c[15:8]};
    x = x ^ {8'h00, b};
    x = x ^ {12'h000, x[7:4]};
    x = x ^ {x[3:0], 12'h000};
    x = x ^ {3'b000, x[7:0], 5'b00000};
    return x;
  endfunction

endpackage

// File: rtl/sdf_front.sv
// Front part: byte history, header compare and selection of CRC and tail bytes.
module sdf_front import sdf_pkg::*; #(
  parameter int MAX_HEADER = MAX_HEADER_DEF
) (
  input  logic                           clk,
  input  logic [$clog2(MAX_HEADER+1)-1:0] hl,
  input  logic [PATTERN_W-1:0]           header_pattern,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic [7:0]                     in_data_byte,
  output logic                           push_valid,
  input  logic                           push_ready,
  output sdf_item_t                      push_item
);

  localparam int HL_W  = $clog2(MAX_HEADER + 1);
  localparam int DLY   = MAX_HEADER + 2;
  localparam int DLY_W = $clog2(DLY);
  localparam int IDX_W = (MAX_HEADER > 1) ? $clog2(MAX_HEADER) : 1;

  logic [7:0]       hist_r [DLY];
  logic [7:0]       win    [MAX_HEADER];
  logic             hit;
  logic [DLY_W-1:0] hl_d;
  logic             take_byte;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign take_byte  = in_valid && push_ready && !in_mode;

  // Window as it stands with the new byte shifted in, newest at index 0.
  always_comb begin
    win[0] = in_data_byte;
    for (int k = 1; k < MAX_HEADER; k++) begin
      win[k] = hist_r[k-1];
    end
  end

  // Header byte i lines up with window byte hl-1-i.
  always_comb begin
    logic [HL_W-1:0] kk;
    hit = 1'b1;
    for (int i = 0; i < MAX_HEADER; i++) begin
      kk = hl - HL_W'(i + 1);
      if (HL_W'(i) < hl) begin
        if (win[kk[IDX_W-1:0]] != header_pattern[8*i +: 8]) begin
          hit = 1'b0;
        end
      end
    end
  end

  assign hl_d = DLY_W'(hl);

  always_comb begin
    push_item.tick     = in_mode;
    push_item.hit      = hit;
    push_item.crc_byte = hist_r[hl_d + DLY_W'(1)];
    push_item.tail     = {hist_r[hl_d], hist_r[hl_d - DLY_W'(1)]};
  end

  // Advance the history on data beats only.
  always_ff @(posedge clk) begin
    if (take_byte) begin
      hist_r[0] <= in_data_byte;
      for (int j = 1; j < DLY; j++) begin
        hist_r[j] <= hist_r[j-1];
      end
    end
  end

endmodule

// File: rtl/sdf_queue.sv
// Short queue of classified beats between the front and back parts.
module sdf_queue import sdf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  sdf_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output sdf_item_t pop_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sdf_item_t        slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/sdf_back.sv
// Back part: frame tracking, CRC accumulation, good-frame count and result register.
module sdf_back import sdf_pkg::*; #(
  parameter int MAX_HEADER = MAX_HEADER_DEF,
  parameter int MAX_HELD   = MAX_HELD_DEF,
  parameter int MIN_FRAME  = MIN_FRAME_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [$clog2(MAX_HEADER+1)-1:0] hl,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  sdf_item_t                       pop_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output status_t                         out_status,
  output logic [15:0]                     out_frame_length,
  output logic [15:0]                     out_frames_per_second
);

  // Held count peaks at MAX_HELD + 2 before it is compared.
  localparam int CNT_W = $clog2(MAX_HELD + 3);

  logic             in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [CNT_W-1:0] fcnt_r, fcnt_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      good_r, good_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [15:0]      out_len_r, out_len_nxt;
  logic [15:0]      out_fps_r, out_fps_nxt;

  logic             fire;
  logic [CNT_W-1:0] hl_c, held_inc, fcnt_inc, flen;
  logic [15:0]      crc_upd;
  logic             match;

  assign pop_ready = !out_valid_r || out_ready;
  assign fire      = pop_valid && pop_ready;

  always_comb begin
    hl_c     = CNT_W'(hl);
    held_inc = held_r + CNT_W'(1);
    fcnt_inc = in_frame_r ? fcnt_r + CNT_W'(1) : fcnt_r;
    crc_upd  = (in_frame_r && fcnt_inc >= hl_c + CNT_W'(CRC_LAG)) ?
               crc16_byte(crc_r, pop_item.crc_byte) : crc_r;
    match    = pop_item.hit && (held_inc >= hl_c);
    flen     = (fcnt_inc >= hl_c) ? fcnt_inc - hl_c : '0;

    in_frame_nxt   = in_frame_r;
    held_nxt       = held_r;
    fcnt_nxt       = fcnt_r;
    crc_nxt        = crc_r;
    good_nxt       = good_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_len_nxt    = out_len_r;
    out_fps_nxt    = out_fps_r;

    if (fire) begin
      if (pop_item.tick) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_RATE;
        out_len_nxt    = '0;
        out_fps_nxt    = good_r;
        good_nxt       = '0;
      end else if (match) begin
        if (in_frame_r) begin
          // Close the running frame at the start of the new header.
          out_valid_nxt = 1'b1;
          out_len_nxt   = 16'(flen);
          out_fps_nxt   = '0;
          if (flen < CNT_W'(MIN_FRAME)) begin
            out_status_nxt = ST_SHORT;
          end else if (crc_upd == pop_item.tail) begin
            out_status_nxt = ST_GOOD;
            if (good_r != 16'hffff) begin
              good_nxt = good_r + 16'd1;
            end
          end else begin
            out_status_nxt = ST_BAD_CRC;
          end
          held_nxt = hl_c;
        end else begin
          held_nxt = held_inc;
        end
        in_frame_nxt = 1'b1;
        fcnt_nxt     = hl_c;
        crc_nxt      = '0;
      end else if (held_inc > CNT_W'(MAX_HELD)) begin
        // Drop everything held.
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OVERFLOW;
        out_len_nxt    = '0;
        out_fps_nxt    = '0;
        in_frame_nxt   = 1'b0;
        held_nxt       = '0;
        fcnt_nxt       = '0;
        crc_nxt        = '0;
      end else begin
        held_nxt = held_inc;
        fcnt_nxt = fcnt_inc;
        crc_nxt  = crc_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      held_r      <= '0;
      fcnt_r      <= '0;
      crc_r       <= '0;
      good_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_frame_r  <= in_frame_nxt;
      held_r      <= held_nxt;
      fcnt_r      <= fcnt_nxt;
      crc_r       <= crc_nxt;
      good_r      <= good_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_len_r    <= out_len_nxt;
    out_fps_r    <= out_fps_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_frame_length      = out_len_r;
  assign out_frames_per_second = out_fps_r;

endmodule

// File: rtl/sync_header_deframer_crc16_check.sv
// Top level of the sync-header deframer with CRC-16 frame check.
//
// Takes one beat per cycle when in_ready is high: a serial byte (in_mode 0)
// or a one-second tick (in_mode 1), and gives at most one result beat for
// each. Every byte position is compared with a header of 1 to MAX_HEADER
// bytes (cfg register 0 holds the pattern, first header byte in bits 7..0;
// register 1 the length, where 0 acts as 1 and values above MAX_HEADER act
// as MAX_HEADER). A frame runs from one header start to the next; on close
// it is reported as good, bad CRC or too short (below MIN_FRAME bytes). The
// CRC is CRC-16 poly 0x1021, init 0, over the frame without its first byte
// and last two bytes, checked against those two bytes big-endian. When more
// than MAX_HELD bytes pile up with no frame close, the stream state is
// dropped and an overflow result is given. A tick reports and clears the
// saturating good-frame count. Throughput is one beat per clock, sustained
// while out_ready holds high: the front compares the header and picks the
// CRC and tail bytes in the accept cycle, and the back runs one byte-wide
// CRC step per cycle. When nothing stalls, out_valid rises at the clock edge
// after the one that accepts the beat; the two-entry queue and the output
// register let either side stall without a bubble. Write configuration only
// while no beat is in flight. No clearing pass follows reset.
module sync_header_deframer_crc16_check import sdf_pkg::*; #(
  parameter int MAX_HEADER = MAX_HEADER_DEF,
  parameter int MAX_HELD   = MAX_HELD_DEF,
  parameter int MIN_FRAME  = MIN_FRAME_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input beats
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [7:0]           in_data_byte,
  // Result beats
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [15:0]          out_frame_length,
  output logic [15:0]          out_frames_per_second,
  // Configuration writes
  input  logic                 cfg_wr_en,
  input  logic                 cfg_index,
  input  logic [PATTERN_W-1:0] cfg_wdata
);

  localparam int HL_W = $clog2(MAX_HEADER + 1);

  logic [PATTERN_W-1:0] pattern_r;
  logic [HLEN_W-1:0]    hlen_r;
  logic [HL_W-1:0]      hl;

  logic      push_valid, push_ready;
  sdf_item_t push_item;
  logic      pop_valid, pop_ready;
  sdf_item_t pop_item;
  status_t   status;

  // Hold the configuration; the header length resets to one byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      hlen_r    <= HLEN_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IDX_PATTERN: pattern_r <= cfg_wdata;
        CFG_IDX_LENGTH:  hlen_r    <= cfg_wdata[HLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the header length into 1..MAX_HEADER.
  always_comb begin
    if (hlen_r == '0) begin
      hl = HL_W'(1);
    end else if (hlen_r > HLEN_W'(MAX_HEADER)) begin
      hl = HL_W'(MAX_HEADER);
    end else begin
      hl = HL_W'(hlen_r);
    end
  end

  // Front: accept the beat and classify it against the byte history.
  sdf_front #(
    .MAX_HEADER (MAX_HEADER)
  ) u_front (
    .clk            (clk),
    .hl             (hl),
    .header_pattern (pattern_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_data_byte   (in_data_byte),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  // Decouple the two sides.
  sdf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Back: track frames, run the CRC and register the result.
  sdf_back #(
    .MAX_HEADER (MAX_HEADER),
    .MAX_HELD   (MAX_HELD),
    .MIN_FRAME  (MIN_FRAME)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .hl                    (hl),
    .pop_valid             (pop_valid),
    .pop_ready             (pop_ready),
    .pop_item              (pop_item),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (status),
    .out_frame_length      (out_frame_length),
    .out_frames_per_second (out_frames_per_second)
  );

  assign out_status = status;

endmodule

// File: rtl/sdf_checker.sv
// Port-level checks of the sync-header deframer, bound to its top level.
module sdf_checker import sdf_pkg::*; #(
  parameter int MIN_FRAME = MIN_FRAME_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [15:0] out_frame_length,
  input logic [15:0] out_frames_per_second
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_frame_length) && $stable(out_frames_per_second))
    else $error("result beat changed while stalled");

  // Rate reports and overflow carry no frame length.
  a_no_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_RATE || out_status == ST_OVERFLOW) |->
      out_frame_length == 16'd0)
    else $error("frame length on rate report or overflow");

  // Only a rate report carries the good-frame count.
  a_fps_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_RATE |-> out_frames_per_second == 16'd0)
    else $error("frame rate on a frame result");

  // A too-short frame is below the minimum length.
  a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SHORT |-> out_frame_length < 16'(MIN_FRAME))
    else $error("too-short frame with full length");

endmodule

bind sync_header_deframer_crc16_check sdf_checker #(
  .MIN_FRAME (MIN_FRAME)
) u_sdf_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_status            (out_status),
  .out_frame_length      (out_frame_length),
  .out_frames_per_second (out_frames_per_second)
);

// File: verif/sdf_frame_monitor.sv
// Frame monitor: predicts deframer reports from the observed beats and compares them.
`timescale 1ns / 100ps
module sdf_frame_monitor import sdf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_mode,
  input  logic [7:0]           in_data_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [2:0]           out_status,
  input  logic [15:0]          out_frame_length,
  input  logic [15:0]          out_frames_per_second,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_index,
  input  logic [PATTERN_W-1:0] cfg_wdata,
  output int                   mismatches,
  output int                   reports_outstanding
);

  typedef struct {
    status_t     st;
    logic [15:0] len;
    logic [15:0] fps;
  } frame_report_t;

  frame_report_t reports_due[$];
  frame_report_t due;
  int            errors = 0;

  // Shadow of the header registers
  logic [PATTERN_W-1:0] hdr_pat;
  logic [HLEN_W-1:0]    hdr_len;

  // Shadow of the stream state
  logic [63:0] window;
  logic [7:0]  hist [MAX_HEADER_DEF+2];
  bit          framing;
  int          held;
  int          flen;
  logic [15:0] crc;
  logic [15:0] good;

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) x = x[15] ? ({x[14:0], 1'b0} ^ 16'h1021) : {x[14:0], 1'b0};
    return x;
  endfunction

  task automatic clear_stream();
    window  = '0;
    foreach (hist[i]) hist[i] = '0;
    framing = 1'b0;
    held    = 0;
    flen    = 0;
    crc     = '0;
  endtask

  task automatic push_report(input status_t st, input int len, input logic [15:0] fps);
    frame_report_t r;
    r.st  = st;
    r.len = len[15:0];
    r.fps = fps;
    reports_due = {reports_due, r};
  endtask

  // Advance the shadow state by one accepted beat and queue its report, if any.
  task automatic deframe_beat(input logic tick, input logic [7:0] b);
    int          hl;
    int          len;
    bit          hit;
    logic [15:0] tail;
    if (tick) begin
      push_report(ST_RATE, 0, good);
      good = '0;
      return;
    end
    hl = (hdr_len == 0) ? 1 : ((hdr_len > MAX_HEADER_DEF) ? MAX_HEADER_DEF : int'(hdr_len));
    window = {window[55:0], b};
    held++;
    if (framing) flen++;
    if (framing && flen >= hl + 4) crc = crc_step(crc, hist[hl+1]);
    tail = {hist[hl], hist[hl-1]};
    hit = (held >= hl);
    for (int i = 0; i < hl; i++) begin
      if (window[8*(hl-1-i) +: 8] != hdr_pat[8*i +: 8]) hit = 1'b0;
    end
    for (int i = MAX_HEADER_DEF + 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = b;
    if (hit) begin
      if (framing) begin
        len = flen - hl;
        if (len < MIN_FRAME_DEF) begin
          push_report(ST_SHORT, len, '0);
        end else if (crc == tail) begin
          push_report(ST_GOOD, len, '0);
          if (good != 16'hffff) good++;
        end else begin
          push_report(ST_BAD_CRC, len, '0);
        end
        held = hl;
      end
      framing = 1'b1;
      flen    = hl;
      crc     = '0;
      return;
    end
    if (held > MAX_HELD_DEF) begin
      clear_stream();
      push_report(ST_OVERFLOW, 0, '0);
    end
  endtask

  task automatic flag(input string what, input int want, input int got);
    errors++;
    $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hdr_pat = '0;
      hdr_len = 4'd1;
      clear_stream();
      good = '0;
      reports_due.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_IDX_PATTERN) hdr_pat = cfg_wdata;
        else hdr_len = cfg_wdata[HLEN_W-1:0];
      end
      // Retire the result first: its beat went in on an earlier cycle.
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          flag("unexpected result beat, status", -1, out_status);
        end else begin
          due = reports_due.pop_front();
          if (out_status !== due.st) flag("status", due.st, out_status);
          if (out_frame_length !== due.len) flag("frame_length", due.len, out_frame_length);
          if (out_frames_per_second !== due.fps)
            flag("frames_per_second", due.fps, out_frames_per_second);
        end
      end
      if (in_valid && in_ready) deframe_beat(in_mode, in_data_byte);
    end
    mismatches          <= errors;
    reports_outstanding <= reports_due.size();
  end

endmodule

// File: verif/sync_header_deframer_crc16_check_tb.sv
// Top of the deframer testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps
module sync_header_deframer_crc16_check_tb;
  import sdf_pkg::*;

  // Cycles with no beat moving on either channel before the run is called hung.
  // Worst honest case is a sender gap plus a receiver stall plus the idle pause.
  localparam int STALL_LIMIT = 2000;
  // Random beats per header setting; six settings give about 1900 beats.
  localparam int PHASE_BEATS = 320;

  typedef logic [7:0] byte_q_t[$];

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_mode;
  logic [7:0]           in_data_byte;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  logic [2:0]           out_status;
  logic [15:0]          out_frame_length;
  logic [15:0]          out_frames_per_second;
  logic                 cfg_wr_en;
  logic                 cfg_index;
  logic [PATTERN_W-1:0] cfg_wdata;

  int mismatches;
  int reports_outstanding;

  // Header currently programmed, as the stimulus sees it
  logic [63:0] hdr_pat = '0;
  int          hdr_len_eff = 1;

  int burst_left = 0;
  int beats_sent = 0;
  int idle_cycles = 0;

  // Receiver stall pattern state
  int stall_mode = 0;
  int mode_left = 0;
  int run_left = 0;

  sync_header_deframer_crc16_check uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_mode               (in_mode),
    .in_data_byte          (in_data_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_frame_length      (out_frame_length),
    .out_frames_per_second (out_frames_per_second),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  sdf_frame_monitor u_monitor (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_mode               (in_mode),
    .in_data_byte          (in_data_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_frame_length      (out_frame_length),
    .out_frames_per_second (out_frames_per_second),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .mismatches            (mismatches),
    .reports_outstanding   (reports_outstanding)
  );

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Receiver: switch between always ready, coin flips, one-in-four, and long
  // stall runs, each mode held for a random stretch.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (mode_left % 4) == 0;
      default: begin
        if (run_left == 0) begin
          out_ready <= !out_ready;
          run_left  <= out_ready ? $urandom_range(1, 16) : $urandom_range(1, 8);
        end else begin
          run_left <= run_left - 1;
        end
      end
    endcase
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("** sync_header_deframer_crc16_check: FAILED **");
        $finish;
      end
    end
  end

  // CRC-16/0x1021, init 0, over a frame without its first byte.
  function automatic logic [15:0] frame_crc(input byte_q_t fr);
    logic [15:0] x;
    x = '0;
    for (int k = 1; k < fr.size(); k++) begin
      x = x ^ {fr[k], 8'h00};
      for (int i = 0; i < 8; i++) x = x[15] ? ({x[14:0], 1'b0} ^ 16'h1021) : {x[14:0], 1'b0};
    end
    return x;
  endfunction

  // Mostly short bodies, now and then a long one.
  function automatic int rand_body_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 24);
  endfunction

  // Send one beat. Bursts of random length with random gaps between them;
  // hold valid and payload until the beat is taken.
  task automatic put_beat(input logic m, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_mode      <= m;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // Build a frame under the current header: header, random body, big-endian
  // CRC. Optionally flip one bit after the header, or drop bytes from its end.
  // A tick may slip in between bytes; it must not disturb the frame.
  task automatic send_frame(input int body_len, input bit corrupt, input int drop);
    byte_q_t     fr;
    logic [15:0] c;
    int          k;
    for (int i = 0; i < hdr_len_eff; i++) fr = {fr, hdr_pat[8*i +: 8]};
    repeat (body_len) fr = {fr, 8'($urandom_range(0, 255))};
    c = frame_crc(fr);
    fr = {fr, c[15:8], c[7:0]};
    if (corrupt) begin
      k = $urandom_range(hdr_len_eff, fr.size() - 1);
      fr[k] = fr[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    repeat (drop) void'(fr.pop_back());
    foreach (fr[i]) begin
      if ($urandom_range(0, 49) == 0) put_beat(1'b1, 8'($urandom_range(0, 255)));
      put_beat(1'b0, fr[i]);
    end
  endtask

  // Drop valid and wait until every report is in, then let the pipeline drain
  // past bytes that report nothing.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_outstanding != 0);
    repeat (6) @(posedge clk);
    burst_left = 0;
  endtask

  // Write pattern then length on back-to-back cycles; block must be idle.
  task automatic set_header(input logic [63:0] pat, input logic [3:0] len);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IDX_PATTERN;
    cfg_wdata <= pat;
    @(posedge clk);
    cfg_index <= CFG_IDX_LENGTH;
    cfg_wdata <= {60'd0, len};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    hdr_pat     = pat;
    hdr_len_eff = (len == 0) ? 1 : ((len > MAX_HEADER_DEF) ? MAX_HEADER_DEF : int'(len));
  endtask

  initial begin
    logic [63:0] pat_list [6];
    logic [3:0]  len_list [6];
    int          phase_start;
    int          r;
    bit          paused;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_mode      <= 1'b0;
    in_data_byte <= '0;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= CFG_IDX_PATTERN;
    cfg_wdata    <= '0;
    paused = 1'b0;

    // Header settings: single byte, full eight, all ones with length 0
    // (acts as 1), all zeros with length 15 (acts as 8), three bytes, and a
    // self-overlapping four-byte pattern.
    pat_list[0] = {$urandom, $urandom};                  len_list[0] = 4'd1;
    pat_list[1] = {$urandom, $urandom};                  len_list[1] = 4'd8;
    pat_list[2] = '1;                                    len_list[2] = 4'd0;
    pat_list[3] = '0;                                    len_list[3] = 4'd15;
    pat_list[4] = {$urandom, $urandom};                  len_list[4] = 4'd3;
    pat_list[5] = 64'h5a5a_5a5a_5a5a_5a5a;               len_list[5] = 4'd4;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, under the reset header (one 0x00 byte): a tick with nothing
    // counted, a stray byte before any header, a minimum-length good frame,
    // a bad-CRC frame, back-to-back headers giving a one-byte short frame,
    // then a tick that reports the single good frame.
    put_beat(1'b1, 8'hff);
    put_beat(1'b0, 8'hff);
    send_frame(6, 1'b0, 0);
    send_frame(6, 1'b1, 0);
    put_beat(1'b0, 8'h00);
    put_beat(1'b0, 8'h00);
    put_beat(1'b1, 8'h00);

    for (int p = 0; p < 6; p++) begin
      settle();
      set_header(pat_list[p], len_list[p]);
      phase_start = beats_sent;
      while (beats_sent < phase_start + PHASE_BEATS) begin
        // Hold off once, midway through the second phase, until the block has caught up.
        if (p == 1 && !paused && beats_sent >= phase_start + PHASE_BEATS / 2) begin
          settle();
          paused = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 70) send_frame(rand_body_len(), 1'b0, 0);
        else if (r < 82) send_frame(rand_body_len(), 1'b1, 0);
        else if (r < 88) send_frame(rand_body_len(), 1'b0, $urandom_range(1, 3));
        else if (r < 94) repeat ($urandom_range(1, 6)) put_beat(1'b0, 8'($urandom_range(0, 255)));
        else if (r < 97) repeat ($urandom_range(1, 10)) put_beat(1'b0, hdr_pat[7:0]);
        else put_beat(1'b1, 8'($urandom_range(0, 255)));
      end
    end

    // Drain: wait out every report before giving the verdict.
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_outstanding != 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("** sync_header_deframer_crc16_check: PASSED **");
    end else begin
      $display("** sync_header_deframer_crc16_check: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/sdf_pkg.sv
rtl/sdf_front.sv
rtl/sdf_queue.sv
rtl/sdf_back.sv
rtl/sync_header_deframer_crc16_check.sv
rtl/sdf_checker.sv
verif/sdf_frame_monitor.sv
verif/sync_header_deframer_crc16_check_tb.sv
